FILE: src/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the particle level set splat block.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int MAX_NODES_X_DEF = 16;
  localparam int MAX_NODES_Y_DEF = 16;
  localparam int MAX_NODES_Z_DEF = 16;

  localparam int OP_W      = 2;
  localparam int POS_W     = 32;
  localparam int NODE_W    = 4;
  localparam int SIZE_W    = 31;
  localparam int CNT_W     = 5;
  localparam int LEVEL_W   = 32;
  localparam int ACC_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z     = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RST = 31'd65536;
  localparam logic [CNT_W-1:0]  CNT_RST  = 5'd16;

  localparam int RAVG_MUL  = 87;
  localparam int RAVG_BIAS = 50;
  localparam int RAVG_DIV  = 100;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [NODE_W-1:0]        node_i;
    logic [NODE_W-1:0]        node_j;
    logic [NODE_W-1:0]        node_k;
    logic                     node_is_fluid;
  } pls_in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_value;
    logic                      from_particles;
  } pls_out_t;

  typedef struct packed {
    logic [ACC_W-1:0] sum_x;
    logic [ACC_W-1:0] sum_y;
    logic [ACC_W-1:0] sum_z;
    logic [ACC_W-1:0] total;
  } pls_acc_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_PRE, ST_CDIV, ST_CCHK, ST_NODE, ST_DIST, ST_SQ, ST_SUM,
    ST_UDIV, ST_W1, ST_W2, ST_WP, ST_WR, ST_ERD, ST_ECHK, ST_EDIV, ST_EDIFF,
    ST_ESHIFT, ST_ESQ, ST_ESUM, ST_ESQRT, ST_EOUT
  } pls_state_t;

endpackage
`default_nettype wire

FILE: src/pls_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_in_if
// Input item channel: valid/ready with one input item.
// ----------------------------------------------------------------------------
interface pls_in_if;
  import pls_pkg::*;
  logic    valid;
  logic    ready;
  pls_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/pls_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_out_if
// Result item channel: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface pls_out_if;
  import pls_pkg::*;
  logic     valid;
  logic     ready;
  pls_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/pls_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_div
// Restoring divider, one quotient bit per cycle. Quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module pls_div #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quot
);
  localparam int RW = (NW > DW + QW) ? NW : DW + QW;
  localparam int CW = $clog2(QW + 1);

  logic [RW-1:0] rem_r;
  logic [RW-1:0] dsh_r;
  logic [QW-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          fit;

  assign fit  = rem_r >= dsh_r;
  assign busy = busy_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= RW'(num);
      dsh_r  <= RW'(den) << (QW - 1);
      quot_r <= '0;
    end else if (busy_r) begin
      if (fit) rem_r <= rem_r - dsh_r;
      quot_r <= {quot_r[QW-2:0], fit};
      dsh_r  <= dsh_r >> 1;
    end
  end
endmodule
`default_nettype wire

FILE: src/pls_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module pls_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pls_pkg::ACC_W-1:0]   radicand,
  output logic                        busy,
  output logic [pls_pkg::ACC_W/2-1:0] root
);
  import pls_pkg::*;

  localparam int STEPS = ACC_W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [ACC_W-1:0] val_r;
  logic [ACC_W-1:0] res_r;
  logic [ACC_W-1:0] bit_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [ACC_W-1:0] trial;

  assign trial = res_r + bit_r;
  assign busy  = busy_r;
  assign root  = res_r[ACC_W/2-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= radicand;
      res_r <= '0;
      bit_r <= ACC_W'(1) << (ACC_W - 2);
    end else if (busy_r) begin
      if (val_r >= trial) begin
        val_r <= val_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end
endmodule
`default_nettype wire

FILE: src/particle_level_set_splat_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_level_set_splat_core
// Splats particles into per-node accumulators and evaluates level set values.
//
// Items arrive on in_ch (valid/ready); operation 0 clears the accumulators,
// 1 adds a particle, 2 evaluates a node. Only evaluations of nodes inside the
// grid produce a result item on out_ch. Configuration is written on cfg_we /
// cfg_index / cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. One item is worked on at a time;
// in_ch.ready is high only when idle. Clear: one accumulator entry per cycle,
// over all MAX_NODES_X*Y*Z entries. Add: the cell index divide, then for each
// neighborhood node a skip, or the kernel divide and the read-modify-write of
// the accumulator memory. Evaluate: the mean divide, then the square root.
// After reset the accumulator memory is swept to zero before the first item
// is taken. A finished result sits in an output register; a stalled receiver
// holds the next evaluation at its end until that register frees.
// ----------------------------------------------------------------------------
module particle_level_set_splat_core #(
  parameter int MAX_NODES_X = pls_pkg::MAX_NODES_X_DEF,
  parameter int MAX_NODES_Y = pls_pkg::MAX_NODES_Y_DEF,
  parameter int MAX_NODES_Z = pls_pkg::MAX_NODES_Z_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pls_in_if.sink                          in_ch,
  pls_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pls_pkg::SIZE_W-1:0]      cfg_wdata
);
  import pls_pkg::*;

  localparam int DEPTH = MAX_NODES_X * MAX_NODES_Y * MAX_NODES_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXXY = (MAX_NODES_X > MAX_NODES_Y) ? MAX_NODES_X : MAX_NODES_Y;
  localparam int MAXN  = (MAXXY > MAX_NODES_Z) ? MAXXY : MAX_NODES_Z;
  localparam int CW    = $clog2(MAXN + 1);
  localparam int SH_MAX = 10;
  // 0.87h: (87h + 50) / 100 taken as ((87h + 50) >> 2) / 25 by reciprocal
  localparam logic [36:0] RAVG_RECIP = 37'd87960930223;
  localparam int          RAVG_SH    = 41;

  function automatic logic signed [31:0] mean_of(input logic [31:0] q, input logic neg,
                                                 input logic sat);
    logic signed [31:0] r;
    if (neg) r = (sat || q > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q);
    else     r = (sat || q > 32'h7fff_ffff) ? 32'sh7fff_ffff : $signed(q);
    return r;
  endfunction

  pls_state_t state_r, state_nxt;

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [CNT_W-1:0]  cells_x_r, cells_y_r, cells_z_r;
  logic [SIZE_W-1:0] sx_e, sy_e, sz_e;
  logic [CW-1:0]     nx, ny, nz;

  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  logic [NODE_W-1:0]       ei_r, ej_r, ek_r;
  logic                    fluid_r;
  logic [AW-1:0]           addr_r;
  logic [61:0]             hsq_r;
  logic [CW-1:0]           cx_r, cy_r, cz_r;
  logic [5:0]              o_r;
  logic [CW-1:0]           ni_r, nj_r, nk_r;
  logic [40:0]             ax_r, ay_r, az_r;
  logic [61:0]             sq_x_r, sq_y_r, sq_z_r;
  logic [33:0]             uu_r;
  logic [16:0]             w_r;
  logic signed [49:0]      prod_x_r, prod_y_r, prod_z_r;
  logic                    neg_x_r, neg_y_r, neg_z_r;
  logic                    sat_x_r, sat_y_r, sat_z_r;
  logic [3:0]              sh_r;
  logic [54:0]             rv_lo_r, rv_hi_r;
  logic [31:0]             ravg_r;
  logic signed [LEVEL_W-1:0] lvl_r;
  logic                    fromp_r;
  logic                    out_valid_r;
  pls_out_t                out_data_r;

  pls_acc_t mem [DEPTH];
  pls_acc_t rdata_r;
  pls_acc_t wdata;
  logic     mem_we, mem_re;

  // Controls
  logic accept, adv, last_o, load_out;
  logic div_start, udiv_start, sqrt_start;
  logic cidx_out, cidx_in, node_ok, skip_sq, skip_sum, eval_ok, clr_last;

  // Datapath combinational
  logic signed [63:0] cnum_x, cnum_y, cnum_z;
  logic [63:0]        cden_x, cden_y, cden_z;
  logic signed [CW+1:0] ni, nj, nk;
  logic [63:0]        s2;
  logic [63:0]        mag_x, mag_y, mag_z;
  logic               msat_x, msat_y, msat_z;
  logic [63:0]        dnum_x, dnum_y, dnum_z, dden_x, dden_yz;
  logic [31:0]        q_x, q_y, q_z;
  logic [16:0]        uq;
  logic               bx, by, bz, bu, bs;
  logic [31:0]        root;
  logic [63:0]        rad;
  logic signed [31:0] mean_x, mean_y, mean_z;
  logic signed [41:0] ed_x, ed_y, ed_z;
  logic signed [41:0] sd_x, sd_y, sd_z;
  logic [40:0]        mmax;
  logic [3:0]         sh;
  logic [43:0]        root_sh;
  logic signed [44:0] lev;
  logic [31:0]        half;
  logic [37:0]        ravg_num;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r  <= SIZE_RST;
      size_y_r  <= SIZE_RST;
      size_z_r  <= SIZE_RST;
      cells_x_r <= CNT_RST;
      cells_y_r <= CNT_RST;
      cells_z_r <= CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE_X: size_x_r  <= cfg_wdata;
        CFG_CELL_SIZE_Y: size_y_r  <= cfg_wdata;
        CFG_CELL_SIZE_Z: size_z_r  <= cfg_wdata;
        CFG_CELLS_X:     cells_x_r <= cfg_wdata[CNT_W-1:0];
        CFG_CELLS_Y:     cells_y_r <= cfg_wdata[CNT_W-1:0];
        CFG_CELLS_Z:     cells_z_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign sx_e = (size_x_r == '0) ? SIZE_W'(1) : size_x_r;
  assign sy_e = (size_y_r == '0) ? SIZE_W'(1) : size_y_r;
  assign sz_e = (size_z_r == '0) ? SIZE_W'(1) : size_z_r;
  assign nx = (cells_x_r == '0) ? CW'(1) :
              ((int'(cells_x_r) > MAX_NODES_X) ? CW'(MAX_NODES_X) : CW'(cells_x_r));
  assign ny = (cells_y_r == '0) ? CW'(1) :
              ((int'(cells_y_r) > MAX_NODES_Y) ? CW'(MAX_NODES_Y) : CW'(cells_y_r));
  assign nz = (cells_z_r == '0) ? CW'(1) :
              ((int'(cells_z_r) > MAX_NODES_Z) ? CW'(MAX_NODES_Z) : CW'(cells_z_r));

  // Accumulator memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_r] <= wdata;
    if (mem_re) rdata_r <= mem[addr_r];
  end

  // Conditions
  always_comb begin
    accept   = in_ch.valid && in_ch.ready;
    last_o   = &o_r;
    clr_last = addr_r == AW'(DEPTH - 1);
    eval_ok  = (int'(in_ch.data.node_i) < int'(nx)) && (int'(in_ch.data.node_j) < int'(ny)) &&
               (int'(in_ch.data.node_k) < int'(nz));

    cnum_x = (64'(px_r) <<< 1) + 64'(sx_e);
    cnum_y = (64'(py_r) <<< 1) + 64'(sy_e);
    cnum_z = (64'(pz_r) <<< 1) + 64'(sz_e);
    cden_x = 64'(sx_e) << 1;
    cden_y = 64'(sy_e) << 1;
    cden_z = 64'(sz_e) << 1;
    cidx_out = cnum_x[63] || cnum_y[63] || cnum_z[63] ||
               ($unsigned(cnum_x) >= cden_x * 64'(MAX_NODES_X)) ||
               ($unsigned(cnum_y) >= cden_y * 64'(MAX_NODES_Y)) ||
               ($unsigned(cnum_z) >= cden_z * 64'(MAX_NODES_Z));
    cidx_in  = (q_x < 32'(nx)) && (q_y < 32'(ny)) && (q_z < 32'(nz));

    ni = $signed({2'b00, cx_r}) + $signed((CW+2)'(o_r[1:0])) - $signed((CW+2)'(2));
    nj = $signed({2'b00, cy_r}) + $signed((CW+2)'(o_r[3:2])) - $signed((CW+2)'(2));
    nk = $signed({2'b00, cz_r}) + $signed((CW+2)'(o_r[5:4])) - $signed((CW+2)'(2));
    node_ok = !ni[CW+1] && (ni[CW:0] < {1'b0, nx}) &&
              !nj[CW+1] && (nj[CW:0] < {1'b0, ny}) &&
              !nk[CW+1] && (nk[CW:0] < {1'b0, nz});

    skip_sq  = (ax_r >= 41'(sx_e)) || (ay_r >= 41'(sx_e)) || (az_r >= 41'(sx_e));
    s2       = 64'(sq_x_r) + 64'(sq_y_r) + 64'(sq_z_r);
    skip_sum = s2 >= 64'(hsq_r);

    mag_x  = rdata_r.sum_x[63] ? -rdata_r.sum_x : rdata_r.sum_x;
    mag_y  = rdata_r.sum_y[63] ? -rdata_r.sum_y : rdata_r.sum_y;
    mag_z  = rdata_r.sum_z[63] ? -rdata_r.sum_z : rdata_r.sum_z;
    msat_x = {32'b0, mag_x} >= {rdata_r.total, 32'b0};
    msat_y = {32'b0, mag_y} >= {rdata_r.total, 32'b0};
    msat_z = {32'b0, mag_z} >= {rdata_r.total, 32'b0};

    mean_x = mean_of(q_x, neg_x_r, sat_x_r);
    mean_y = mean_of(q_y, neg_y_r, sat_y_r);
    mean_z = mean_of(q_z, neg_z_r, sat_z_r);
    ed_x = $signed(42'(ei_r) * 42'(sx_e)) - 42'(mean_x);
    ed_y = $signed(42'(ej_r) * 42'(sy_e)) - 42'(mean_y);
    ed_z = $signed(42'(ek_r) * 42'(sz_e)) - 42'(mean_z);
    sd_x = $signed(42'(ni_r) * 42'(sx_e)) - 42'(px_r);
    sd_y = $signed(42'(nj_r) * 42'(sy_e)) - 42'(py_r);
    sd_z = $signed(42'(nk_r) * 42'(sz_e)) - 42'(pz_r);

    mmax = (ax_r > ay_r) ? ax_r : ay_r;
    if (az_r > mmax) mmax = az_r;
    sh = 4'(SH_MAX);
    for (int s = SH_MAX; s >= 0; s--) begin
      if ((mmax >> s) < 41'h0_8000_0000) sh = 4'(s);
    end

    ravg_num = 38'(sx_e) * 38'(RAVG_MUL) + 38'(RAVG_BIAS);
    root_sh  = 44'(root) << sh_r;
    lev  = $signed({1'b0, root_sh}) - $signed(45'(ravg_r));
    half = {1'b0, sx_e[SIZE_W-1:1]};
    rad  = 64'(sq_x_r) + 64'(sq_y_r) + 64'(sq_z_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.data.operation)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_ADD:   state_nxt = ST_PRE;
            OP_EVAL:  state_nxt = eval_ok ? ST_ERD : ST_IDLE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PRE:   state_nxt = cidx_out ? ST_IDLE : ST_CDIV;
      ST_CDIV:  if (!(bx || by || bz)) state_nxt = ST_CCHK;
      ST_CCHK:  state_nxt = cidx_in ? ST_NODE : ST_IDLE;
      ST_NODE:  state_nxt = node_ok ? ST_DIST : (last_o ? ST_IDLE : ST_NODE);
      ST_DIST:  state_nxt = ST_SQ;
      ST_SQ:    state_nxt = skip_sq ? (last_o ? ST_IDLE : ST_NODE) : ST_SUM;
      ST_SUM:   state_nxt = skip_sum ? (last_o ? ST_IDLE : ST_NODE) : ST_UDIV;
      ST_UDIV:  if (!bu) state_nxt = ST_W1;
      ST_W1:    state_nxt = ST_W2;
      ST_W2:    state_nxt = ST_WP;
      ST_WP:    state_nxt = ST_WR;
      ST_WR:    state_nxt = last_o ? ST_IDLE : ST_NODE;
      ST_ERD:   state_nxt = ST_ECHK;
      ST_ECHK:  state_nxt = (rdata_r.total == '0) ? ST_EOUT : ST_EDIV;
      ST_EDIV:  if (!(bx || by || bz)) state_nxt = ST_EDIFF;
      ST_EDIFF: state_nxt = ST_ESHIFT;
      ST_ESHIFT: state_nxt = ST_ESQ;
      ST_ESQ:   state_nxt = ST_ESUM;
      ST_ESUM:  state_nxt = ST_ESQRT;
      ST_ESQRT: if (!bs) state_nxt = ST_EOUT;
      ST_EOUT:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    udiv_start  = 1'b0;
    sqrt_start  = 1'b0;
    adv         = 1'b0;
    load_out    = 1'b0;
    dnum_x      = '0;
    dnum_y      = '0;
    dnum_z      = '0;
    dden_x      = cden_x;
    dden_yz     = '0;
    wdata       = '0;
    case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_PRE: begin
        div_start = !cidx_out;
        dnum_x    = $unsigned(cnum_x);
        dnum_y    = $unsigned(cnum_y);
        dnum_z    = $unsigned(cnum_z);
        dden_x    = cden_x;
      end
      ST_NODE:  adv = !node_ok;
      ST_SQ:    adv = skip_sq;
      ST_SUM: begin
        adv        = skip_sum;
        udiv_start = !skip_sum;
        mem_re     = !skip_sum;
      end
      ST_WR: begin
        adv         = 1'b1;
        mem_we      = 1'b1;
        wdata.sum_x = rdata_r.sum_x + 64'(prod_x_r);
        wdata.sum_y = rdata_r.sum_y + 64'(prod_y_r);
        wdata.sum_z = rdata_r.sum_z + 64'(prod_z_r);
        wdata.total = rdata_r.total + 64'(w_r);
      end
      ST_ERD:   mem_re = 1'b1;
      ST_ECHK: begin
        div_start = rdata_r.total != '0;
        dnum_x    = msat_x ? '0 : mag_x;
        dnum_y    = msat_y ? '0 : mag_y;
        dnum_z    = msat_z ? '0 : mag_z;
        dden_x    = rdata_r.total;
      end
      ST_ESUM:  sqrt_start = 1'b1;
      ST_EOUT:  load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
    if (state_r == ST_PRE) dden_yz = cden_y;
    else dden_yz = rdata_r.total;
  end

  // Dividers and root
  pls_div #(.NW(64), .DW(64), .QW(32)) u_div_x (
    .clk, .rst_n, .start(div_start), .num(dnum_x), .den(dden_x),
    .busy(bx), .quot(q_x)
  );
  pls_div #(.NW(64), .DW(64), .QW(32)) u_div_y (
    .clk, .rst_n, .start(div_start), .num(dnum_y),
    .den((state_r == ST_PRE) ? cden_y : dden_yz), .busy(by), .quot(q_y)
  );
  pls_div #(.NW(64), .DW(64), .QW(32)) u_div_z (
    .clk, .rst_n, .start(div_start), .num(dnum_z),
    .den((state_r == ST_PRE) ? cden_z : dden_yz), .busy(bz), .quot(q_z)
  );
  pls_div #(.NW(78), .DW(62), .QW(17)) u_div_u (
    .clk, .rst_n, .start(udiv_start), .num({hsq_r - s2[61:0], 16'b0}), .den(hsq_r),
    .busy(bu), .quot(uq)
  );
  pls_isqrt u_sqrt (
    .clk, .rst_n, .start(sqrt_start), .radicand(rad), .busy(bs), .root(root)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      o_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) addr_r <= addr_r + AW'(1);
      else if (accept && in_ch.data.operation == OP_CLEAR) addr_r <= '0;
      else if (accept)
        addr_r <= AW'(int'(in_ch.data.node_i) + int'(in_ch.data.node_j) * MAX_NODES_X +
                      int'(in_ch.data.node_k) * MAX_NODES_X * MAX_NODES_Y);
      else if (state_r == ST_DIST)
        addr_r <= AW'(int'(ni_r) + int'(nj_r) * MAX_NODES_X +
                      int'(nk_r) * MAX_NODES_X * MAX_NODES_Y);
      if (state_r == ST_CCHK) o_r <= '0;
      else if (adv) o_r <= o_r + 6'd1;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r    <= in_ch.data.pos_x;
      py_r    <= in_ch.data.pos_y;
      pz_r    <= in_ch.data.pos_z;
      ei_r    <= in_ch.data.node_i;
      ej_r    <= in_ch.data.node_j;
      ek_r    <= in_ch.data.node_k;
      fluid_r <= in_ch.data.node_is_fluid;
    end
    case (state_r)
      ST_PRE:  hsq_r <= 62'(sx_e) * 62'(sx_e);
      ST_CCHK: begin
        cx_r <= CW'(q_x);
        cy_r <= CW'(q_y);
        cz_r <= CW'(q_z);
      end
      ST_NODE: begin
        ni_r <= ni[CW-1:0];
        nj_r <= nj[CW-1:0];
        nk_r <= nk[CW-1:0];
      end
      ST_DIST: begin
        ax_r <= sd_x[41] ? 41'(-sd_x) : sd_x[40:0];
        ay_r <= sd_y[41] ? 41'(-sd_y) : sd_y[40:0];
        az_r <= sd_z[41] ? 41'(-sd_z) : sd_z[40:0];
      end
      ST_SQ: begin
        sq_x_r <= 62'(ax_r[30:0]) * 62'(ax_r[30:0]);
        sq_y_r <= 62'(ay_r[30:0]) * 62'(ay_r[30:0]);
        sq_z_r <= 62'(az_r[30:0]) * 62'(az_r[30:0]);
      end
      ST_W1: uu_r <= 34'(uq) * 34'(uq);
      ST_W2: w_r  <= 17'((51'(uu_r) * 51'(uq)) >> 32);
      ST_WP: begin
        prod_x_r <= $signed({1'b0, w_r}) * px_r;
        prod_y_r <= $signed({1'b0, w_r}) * py_r;
        prod_z_r <= $signed({1'b0, w_r}) * pz_r;
      end
      ST_ECHK: begin
        neg_x_r <= rdata_r.sum_x[63];
        neg_y_r <= rdata_r.sum_y[63];
        neg_z_r <= rdata_r.sum_z[63];
        sat_x_r <= msat_x;
        sat_y_r <= msat_y;
        sat_z_r <= msat_z;
        lvl_r   <= fluid_r ? -$signed(half) : $signed(half);
        fromp_r <= 1'b0;
      end
      ST_EDIFF: begin
        ax_r <= ed_x[41] ? 41'(-ed_x) : ed_x[40:0];
        ay_r <= ed_y[41] ? 41'(-ed_y) : ed_y[40:0];
        az_r <= ed_z[41] ? 41'(-ed_z) : ed_z[40:0];
      end
      ST_ESHIFT: begin
        sh_r    <= sh;
        ax_r    <= ax_r >> sh;
        ay_r    <= ay_r >> sh;
        az_r    <= az_r >> sh;
        rv_lo_r <= 55'(ravg_num[19:2]) * 55'(RAVG_RECIP);
      end
      ST_ESQ: begin
        sq_x_r  <= 62'(ax_r[30:0]) * 62'(ax_r[30:0]);
        sq_y_r  <= 62'(ay_r[30:0]) * 62'(ay_r[30:0]);
        sq_z_r  <= 62'(az_r[30:0]) * 62'(az_r[30:0]);
        rv_hi_r <= 55'(ravg_num[37:20]) * 55'(RAVG_RECIP);
      end
      ST_ESUM: ravg_r <= 32'(({rv_hi_r, 18'b0} + 73'(rv_lo_r)) >> RAVG_SH);
      ST_ESQRT: begin
        lvl_r   <= (lev > 45'sh0_7fff_ffff) ? 32'sh7fff_ffff : lev[31:0];
        fromp_r <= 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_data_r.level_value    <= lvl_r;
      out_data_r.from_particles <= fromp_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
`default_nettype wire

FILE: tb/sv/tb_particle_level_set_splat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_level_set_splat_core
// Self-checking bench for the particle level set splat core. A behavioral
// model of the splat accumulators and the node evaluation predicts every
// level value; results are compared field by field in arrival order. Runs a
// directed set, then random phases over several grid and cell size settings
// with random idling on both channels in all but the last phase.
// ----------------------------------------------------------------------------
module tb_particle_level_set_splat_core;
  import pls_pkg::*;

  localparam int NODES = MAX_NODES_X_DEF * MAX_NODES_Y_DEF * MAX_NODES_Z_DEF;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 5000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0] cfg_wdata;

  pls_in_if  in_if ();
  pls_out_if out_if ();

  particle_level_set_splat_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // model state
  bit [SIZE_W-1:0] size_x, size_y, size_z;
  bit [CNT_W-1:0]  count_x, count_y, count_z;
  bit [63:0] acc_sum_x [NODES];
  bit [63:0] acc_sum_y [NODES];
  bit [63:0] acc_sum_z [NODES];
  bit [63:0] acc_total [NODES];

  pls_out_t level_queue[$];
  int       errors;
  bit       quiet;
  int       idle_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- model
  function automatic longint eff_size(bit [SIZE_W-1:0] r);
    return (r == 0) ? 1 : longint'(r);
  endfunction

  function automatic longint eff_count(bit [CNT_W-1:0] r, longint mx);
    if (r == 0) return 1;
    return (longint'(r) > mx) ? mx : longint'(r);
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint mean_pos(bit [63:0] num, bit [63:0] tot);
    bit [63:0] m, q;
    m = num[63] ? -num : num;
    q = m / tot;
    if (num[63]) return (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
    return (q > 64'h7fff_ffff) ? 64'sh7fff_ffff : longint'(q);
  endfunction

  function automatic int node_addr(longint i, longint j, longint k);
    return int'(i + j * MAX_NODES_X_DEF + k * MAX_NODES_X_DEF * MAX_NODES_Y_DEF);
  endfunction

  task automatic splat_particle(longint px, longint py, longint pz);
    longint sxs, sys, szs, nx, ny, nz, cx, cy, cz, i, j, k;
    bit [63:0] h, hsq, ax, ay, az, s2, r, u, w;
    bit [79:0] frac;
    int a;
    sxs = eff_size(size_x);
    sys = eff_size(size_y);
    szs = eff_size(size_z);
    nx = eff_count(count_x, MAX_NODES_X_DEF);
    ny = eff_count(count_y, MAX_NODES_Y_DEF);
    nz = eff_count(count_z, MAX_NODES_Z_DEF);
    cx = floor_div(2 * px + sxs, 2 * sxs);
    cy = floor_div(2 * py + sys, 2 * sys);
    cz = floor_div(2 * pz + szs, 2 * szs);
    h = 64'(sxs);
    hsq = h * h;
    if (cx < 0 || cx >= nx || cy < 0 || cy >= ny || cz < 0 || cz >= nz) return;
    for (k = (cz < 2 ? 0 : cz - 2); k < ((cz + 2 < nz) ? cz + 2 : nz); k++)
      for (j = (cy < 2 ? 0 : cy - 2); j < ((cy + 2 < ny) ? cy + 2 : ny); j++)
        for (i = (cx < 2 ? 0 : cx - 2); i < ((cx + 2 < nx) ? cx + 2 : nx); i++) begin
          ax = magnitude(i * sxs - px);
          ay = magnitude(j * sys - py);
          az = magnitude(k * szs - pz);
          if (ax >= h || ay >= h || az >= h) continue;
          s2 = ax * ax + ay * ay + az * az;
          if (s2 >= hsq) continue;
          r = hsq - s2;
          frac = {r, 16'h0};
          frac = frac / {16'h0, hsq};
          u = frac[63:0];
          w = (u * u * u) >> 32;
          a = node_addr(i, j, k);
          acc_sum_x[a] += 64'(longint'(w) * px);
          acc_sum_y[a] += 64'(longint'(w) * py);
          acc_sum_z[a] += 64'(longint'(w) * pz);
          acc_total[a] += w;
        end
  endtask

  task automatic predict_item(pls_in_t it);
    longint i, j, k, h, level, ravg;
    bit [63:0] tot, ax, ay, az, m, span;
    int sh, a;
    pls_out_t res;
    case (it.operation)
      OP_CLEAR: begin
        for (a = 0; a < NODES; a++) begin
          acc_sum_x[a] = 0;
          acc_sum_y[a] = 0;
          acc_sum_z[a] = 0;
          acc_total[a] = 0;
        end
      end
      OP_ADD: splat_particle($signed(it.pos_x), $signed(it.pos_y), $signed(it.pos_z));
      OP_EVAL: begin
        i = it.node_i;
        j = it.node_j;
        k = it.node_k;
        h = eff_size(size_x);
        if (i >= eff_count(count_x, MAX_NODES_X_DEF) || j >= eff_count(count_y, MAX_NODES_Y_DEF)
            || k >= eff_count(count_z, MAX_NODES_Z_DEF)) return;
        a = node_addr(i, j, k);
        tot = acc_total[a];
        if (tot == 0) begin
          level = it.node_is_fluid ? -(h >>> 1) : (h >>> 1);
          res.from_particles = 1'b0;
        end else begin
          ax = magnitude(i * h - mean_pos(acc_sum_x[a], tot));
          ay = magnitude(j * eff_size(size_y) - mean_pos(acc_sum_y[a], tot));
          az = magnitude(k * eff_size(size_z) - mean_pos(acc_sum_z[a], tot));
          m = (ax > ay) ? ax : ay;
          if (az > m) m = az;
          sh = 0;
          while ((m >> sh) >= 64'h8000_0000) sh++;
          ax >>= sh;
          ay >>= sh;
          az >>= sh;
          span = int_sqrt(ax * ax + ay * ay + az * az) << sh;
          ravg = (h * RAVG_MUL + RAVG_BIAS) / RAVG_DIV;
          level = longint'(span) - ravg;
          res.from_particles = 1'b1;
        end
        if (level > 64'sh7fff_ffff) level = 64'sh7fff_ffff;
        if (level < -64'sh8000_0000) level = -64'sh8000_0000;
        res.level_value = level[31:0];
        level_queue.push_back(res);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- driving
  task automatic send_item(pls_in_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    predict_item(it);
  endtask

  function automatic pls_in_t make_item(bit [1:0] op, longint px, longint py, longint pz,
                                        int i, int j, int k, bit fluid);
    pls_in_t it;
    it.operation = op;
    it.pos_x = px[31:0];
    it.pos_y = py[31:0];
    it.pos_z = pz[31:0];
    it.node_i = i[3:0];
    it.node_j = j[3:0];
    it.node_k = k[3:0];
    it.node_is_fluid = fluid;
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [SIZE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_CELL_SIZE_X: size_x = value;
      CFG_CELL_SIZE_Y: size_y = value;
      CFG_CELL_SIZE_Z: size_z = value;
      CFG_CELLS_X:     count_x = value[CNT_W-1:0];
      CFG_CELLS_Y:     count_y = value[CNT_W-1:0];
      CFG_CELLS_Z:     count_z = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    wait (level_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(bit [SIZE_W-1:0] sx, bit [SIZE_W-1:0] sy, bit [SIZE_W-1:0] sz,
                          bit [CNT_W-1:0] nx, bit [CNT_W-1:0] ny, bit [CNT_W-1:0] nz);
    wait_idle();
    write_reg(CFG_CELL_SIZE_X, sx);
    write_reg(CFG_CELL_SIZE_Y, sy);
    write_reg(CFG_CELL_SIZE_Z, sz);
    write_reg(CFG_CELLS_X, SIZE_W'(nx));
    write_reg(CFG_CELLS_Y, SIZE_W'(ny));
    write_reg(CFG_CELLS_Z, SIZE_W'(nz));
  endtask

  // position near a random node in use, clamped to the 32-bit range
  function automatic longint grid_pos(longint s, longint n);
    longint v;
    v = longint'($urandom_range(0, int'(n - 1))) * s + (longint'($urandom) % s) - s / 2;
    if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    longint one;
    one = 65536;
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_EVAL, 0, 0, 0, 15, 15, 15, 1'b0));
    send_item(make_item(OP_ADD, 3 * one, 3 * one, 3 * one, 0, 0, 0, 1'b0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 3, 3, 3, 1'b0));
    send_item(make_item(OP_ADD, 3 * one + 20000, 3 * one - 9000, 3 * one + 1, 0, 0, 0, 1'b0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 3, 3, 3, 1'b1));
    send_item(make_item(OP_EVAL, 0, 0, 0, 4, 3, 2, 1'b1));
    // weight rounds to zero: node 0 lies just under h away
    send_item(make_item(OP_ADD, one - 1, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_EVAL, 0, 0, 0, 1, 0, 0, 1'b0));
    // grid corners and outside the grid
    send_item(make_item(OP_ADD, 15 * one + 32767, 15 * one, 15 * one, 0, 0, 0, 1'b0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 15, 15, 15, 1'b0));
    send_item(make_item(OP_ADD, -32768, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ADD, -32769, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ADD, 15 * one + 32768, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ADD, 64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ADD, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                        0, 0, 0, 1'b0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 0, 0, 1'b0));
    // unknown operation carries eval-looking fields
    send_item(make_item(2'd3, 0, 0, 0, 3, 3, 3, 1'b1));
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 3, 3, 3, 1'b0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 15, 15, 15, 1'b1));
  endtask

  task automatic test_random_phase(int n_items);
    longint sx, sy, sz, nx, ny, nz;
    int sel;
    pls_in_t it;
    sx = eff_size(size_x);
    sy = eff_size(size_y);
    sz = eff_size(size_z);
    nx = eff_count(count_x, MAX_NODES_X_DEF);
    ny = eff_count(count_y, MAX_NODES_Y_DEF);
    nz = eff_count(count_z, MAX_NODES_Z_DEF);
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      it = make_item(OP_EVAL, longint'($urandom), longint'($urandom), longint'($urandom),
                     $urandom_range(0, int'(nx - 1)), $urandom_range(0, int'(ny - 1)),
                     $urandom_range(0, int'(nz - 1)), 1'($urandom));
      if (sel < 1) begin
        it.operation = OP_CLEAR;
      end else if (sel < 50) begin
        it.operation = OP_ADD;
        it.pos_x = grid_pos(sx, nx);
        it.pos_y = grid_pos(sy, ny);
        it.pos_z = grid_pos(sz, nz);
      end else if (sel < 56) begin
        it.operation = OP_ADD;
      end else if (sel < 62) begin
        it.node_i = 4'($urandom);
        it.node_j = 4'($urandom);
        it.node_k = 4'($urandom);
      end else if (sel < 64) begin
        it.operation = 2'd3;
      end
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pls_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (level_queue.size() == 0) begin
        report_mismatch("unexpected result", longint'($signed(out_if.data.level_value)), 0);
      end else begin
        want = level_queue.pop_front();
        if (out_if.data.level_value !== want.level_value)
          report_mismatch("level_value", longint'($signed(out_if.data.level_value)),
                          longint'($signed(want.level_value)));
        if (out_if.data.from_particles !== want.from_particles)
          report_mismatch("from_particles", out_if.data.from_particles, want.from_particles);
      end
    end
  end

  int stall_left;
  always @(posedge clk) begin
    if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_particle_level_set_splat_core failed");
      $finish;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    errors       = 0;
    quiet        = 1'b0;
    idle_cycles  = 0;
    stall_left   = 0;
    size_x = SIZE_RST;
    size_y = SIZE_RST;
    size_z = SIZE_RST;
    count_x = CNT_RST;
    count_y = CNT_RST;
    count_z = CNT_RST;
    for (int a = 0; a < NODES; a++) begin
      acc_sum_x[a] = 0;
      acc_sum_y[a] = 0;
      acc_sum_z[a] = 0;
      acc_total[a] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(450);
    set_grid(1, 1, 1, 1, 1, 1);
    test_random_phase(150);
    set_grid(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 16, 31, 2);
    test_random_phase(250);
    set_grid(0, 0, 0, 0, 0, 0);
    test_random_phase(100);
    set_grid(40000, 70000, 23456, 7, 12, 3);
    test_random_phase(400);
    set_grid(SIZE_RST, SIZE_RST, SIZE_RST, CNT_RST, CNT_RST, CNT_RST);
    quiet = 1'b1;
    test_random_phase(500);

    in_if.valid <= 1'b0;
    wait (level_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_particle_level_set_splat_core passed");
    end else begin
      $display("tb_particle_level_set_splat_core failed");
    end
    $finish;
  end

endmodule
